### src/cmwe_pkg.sv
// Shared types and constants for the column melt wipe engine.
`default_nettype none

package cmwe_pkg;

  localparam int unsigned CountW  = 11;
  localparam int unsigned HeightW = 11;
  localparam int unsigned ScaleW  = 8;
  localparam int unsigned ColW    = 10;
  localparam int unsigned RowW    = 10;
  localparam int unsigned OffsW   = 16;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ArithW  = 18;

  localparam logic [CountW-1:0]  ColumnCountRst  = 11'd320;
  localparam logic [HeightW-1:0] ScreenHeightRst = 11'd200;
  localparam logic [ScaleW-1:0]  ScaleRst        = 8'd16;

  localparam logic [CfgIdxW-1:0] CfgColumnCount  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgScale        = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_REPORT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic idle;
    logic tick_start;
    logic walk_rd;
    logic report;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic n_zero;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### src/cmwe_ctrl.sv
// Controller state machine for the tick walk and its report beat.
`default_nettype none

module cmwe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tick_acc_i,
  input  wire cmwe_pkg::status_t status_i,
  output cmwe_pkg::cmd_t         cmd_o
);

  cmwe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmwe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cmwe_pkg::ST_IDLE: begin
        if (tick_acc_i) begin
          state_d = status_i.n_zero ? cmwe_pkg::ST_REPORT : cmwe_pkg::ST_WALK;
        end
      end
      cmwe_pkg::ST_WALK: begin
        if (status_i.idx_last) begin
          state_d = cmwe_pkg::ST_FLUSH;
        end
      end
      cmwe_pkg::ST_FLUSH: begin
        state_d = cmwe_pkg::ST_REPORT;
      end
      cmwe_pkg::ST_REPORT: begin
        if (status_i.out_free) begin
          state_d = cmwe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cmwe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      cmwe_pkg::ST_IDLE: begin
        cmd_o.idle       = 1'b1;
        cmd_o.tick_start = tick_acc_i;
      end
      cmwe_pkg::ST_WALK: begin
        cmd_o.walk_rd = 1'b1;
      end
      cmwe_pkg::ST_FLUSH: begin
        cmd_o = '0;
      end
      cmwe_pkg::ST_REPORT: begin
        cmd_o.report = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/cmwe_datapath.sv
// Offset store, melt arithmetic, query pipeline and output register.
`default_nettype none

module cmwe_datapath #(
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cmwe_pkg::cmd_t                 cmd_i,
  output cmwe_pkg::status_t                   status_o,
  input  wire logic                           acc_i,
  input  wire cmwe_pkg::kind_e                kind_i,
  input  wire logic [cmwe_pkg::ColW-1:0]      column_i,
  input  wire logic [cmwe_pkg::RowW-1:0]      row_i,
  input  wire logic [cmwe_pkg::OffsW-1:0]     offset_i,
  input  wire logic [cmwe_pkg::CountW-1:0]    column_count_i,
  input  wire logic [cmwe_pkg::HeightW-1:0]   screen_height_i,
  input  wire logic [cmwe_pkg::ScaleW-1:0]    scale_i,
  output logic                                s_ready_o,
  output logic                                m_valid_o,
  input  wire logic                           m_ready_i,
  output logic                                wipe_done_o,
  output logic                                use_new_image_o,
  output logic [cmwe_pkg::RowW-1:0]           source_row_o
);

  localparam int unsigned AW = $clog2(MAX_COLUMNS);
  localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned XW = cmwe_pkg::ArithW;
  localparam int unsigned HW = cmwe_pkg::HeightW;

  logic [cmwe_pkg::OffsW-1:0] offs_mem [MAX_COLUMNS];

  logic [AW+cmwe_pkg::ColW-1:0] col_wide;
  logic [AW-1:0]                col_addr;
  logic                         col_in_range;
  logic [CW-1:0]                count_lim;
  logic [CW-1:0]                idx_q, idx_d;
  logic [AW-1:0]                wb_addr_q;
  logic                         wb_q;
  logic                         done_q, done_d;
  logic [cmwe_pkg::OffsW-1:0]   rd_data_q;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [cmwe_pkg::OffsW-1:0]   wr_data;

  logic                         s1_valid_q;
  logic                         s1_query_q;
  logic                         s1_in_range_q;
  logic [cmwe_pkg::RowW-1:0]    s1_row_q;

  logic                         m_valid_q;
  logic                         m_done_q;
  logic                         m_new_q;
  logic [cmwe_pkg::RowW-1:0]    m_src_q;
  logic                         out_free;
  logic                         s1_move;

  logic signed [XW-1:0] d_ext, h16, half, thresh, step, melt, melt_clamp;
  logic                 below;

  logic [cmwe_pkg::OffsW-1:0] q_offs;
  logic [HW-1:0]              q_rows, q_rows_c;
  logic                       q_new;
  logic [cmwe_pkg::RowW-1:0]  q_src;

  // Column decode; the store may be narrower or wider than the column field.
  assign col_wide     = {{AW{1'b0}}, column_i};
  assign col_addr     = col_wide[AW-1:0];
  assign col_in_range = int'(column_i) < MAX_COLUMNS;

  assign count_lim = (int'(column_count_i) < MAX_COLUMNS) ? CW'(column_count_i)
                                                         : CW'(MAX_COLUMNS);

  assign status_o.n_zero   = (count_lim == '0);
  assign status_o.idx_last = (idx_q == count_lim - CW'(1));
  assign status_o.out_free = out_free;

  // Melt rule on the entry read back during a walk.
  assign d_ext  = {{(XW-cmwe_pkg::OffsW){rd_data_q[cmwe_pkg::OffsW-1]}}, rd_data_q};
  assign h16    = {{(XW-HW-4){1'b0}}, screen_height_i, 4'b0000};
  assign half   = {{(XW-cmwe_pkg::ScaleW+1){1'b0}}, scale_i[cmwe_pkg::ScaleW-1:1]};
  assign thresh = {{(XW-cmwe_pkg::ScaleW-4){1'b0}}, scale_i, 4'b0000};
  assign step   = {{(XW-cmwe_pkg::ScaleW-2){1'b0}}, scale_i, 2'b00};
  assign below  = d_ext < h16;

  always_comb begin
    if (d_ext < 0) begin
      melt = d_ext + half;
    end else if (d_ext < thresh) begin
      melt = (d_ext <<< 1) + half;
    end else begin
      melt = d_ext + step;
    end
    melt_clamp = (melt > h16) ? h16 : melt;
  end

  // Query: whole-row offset clamped to 0..height.
  assign q_offs   = s1_in_range_q ? rd_data_q : '0;
  assign q_rows   = q_offs[cmwe_pkg::OffsW-1] ? '0 : q_offs[cmwe_pkg::OffsW-2:4];
  assign q_rows_c = (q_rows > screen_height_i) ? screen_height_i : q_rows;
  assign q_new    = {1'b0, s1_row_q} < q_rows_c;
  assign q_src    = q_new ? s1_row_q : s1_row_q - q_rows_c[cmwe_pkg::RowW-1:0];

  // Store ports.
  assign rd_en   = cmd_i.walk_rd || (acc_i && (kind_i == cmwe_pkg::KIND_QUERY));
  assign rd_addr = cmd_i.walk_rd ? idx_q[AW-1:0] : col_addr;
  assign wr_en   = (wb_q && below) ||
                   (acc_i && (kind_i == cmwe_pkg::KIND_LOAD) && col_in_range);
  assign wr_addr = wb_q ? wb_addr_q : col_addr;
  assign wr_data = wb_q ? melt_clamp[cmwe_pkg::OffsW-1:0] : offset_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      offs_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= offs_mem[rd_addr];
    end
  end

  // Walk counter and done flag.
  always_comb begin
    idx_d  = idx_q;
    done_d = done_q;
    if (cmd_i.tick_start) begin
      idx_d  = '0;
      done_d = 1'b1;
    end else begin
      if (cmd_i.walk_rd) begin
        idx_d = idx_q + CW'(1);
      end
      if (wb_q && below) begin
        done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      done_q <= 1'b0;
      wb_q   <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      done_q <= done_d;
      wb_q   <= cmd_i.walk_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_rd) begin
      wb_addr_q <= idx_q[AW-1:0];
    end
  end

  // Stage one waits for the read data; ticks do not enter it.
  assign out_free  = !m_valid_q || m_ready_i;
  assign s1_move   = s1_valid_q && out_free;
  assign s_ready_o = cmd_i.idle && (!s1_valid_q || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc_i) begin
      s1_valid_q <= (kind_i != cmwe_pkg::KIND_TICK);
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_query_q    <= (kind_i == cmwe_pkg::KIND_QUERY);
      s1_in_range_q <= col_in_range;
      s1_row_q      <= row_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_move || cmd_i.report) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      m_done_q <= done_q;
      m_new_q  <= 1'b0;
      m_src_q  <= '0;
    end else if (s1_move) begin
      m_done_q <= 1'b0;
      m_new_q  <= s1_query_q && q_new;
      m_src_q  <= s1_query_q ? q_src : '0;
    end
  end

  assign m_valid_o       = m_valid_q;
  assign wipe_done_o     = m_done_q;
  assign use_new_image_o = m_new_q;
  assign source_row_o    = m_src_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move || cmd_i.report) |-> (!m_valid_q || m_ready_i))
    else $error("output beat overwritten while stalled");

  a_report_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.report |-> !s1_valid_q)
    else $error("tick report collides with a pending query or load");

  a_wb_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_q |-> !acc_i)
    else $error("item accepted during a column walk");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_rd |-> (idx_q < count_lim))
    else $error("walk index beyond active columns");

endmodule

`default_nettype wire

### src/column_melt_wipe_engine_top.sv
// Top level of the column melt wipe engine: ports, configuration registers, hookup.
`default_nettype none

// Column melt wipe engine. Every screen column holds a signed offset in
// sixteenths of a row, kept in an on-chip store of MAX_COLUMNS entries.
// Input beats carry a kind in s_axis_tuser: load (write one column's offset),
// tick (advance every active column by the melt rule and report whether all
// were already finished) or pixel query (pick new image at the same row or
// old image shifted down by the column's whole-row offset). Each input beat
// yields exactly one output beat, in order. Loads, queries and no-ops are
// taken one per cycle unless a tick is in progress or the output stalls;
// a result passes the registered read of the offset store, then the output
// register. A tick holds the input until its report is presented, also while
// that report waits for the output register to free up: the walk reads one
// column per cycle from the store's single read port and, if the column was
// below the screen bottom, writes the melted value back in the following
// cycle through the write port; a flush state drains the last write and a
// report state presents the report. With a column count of zero the walk is
// skipped. The store has no reset; query or tick a column only after loading
// it. Configuration writes must go in while the engine is idle; not enforced.

module column_melt_wipe_engine_top #(
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tdata: column [9:0], row [19:10], offset_q4 [35:20], zero [39:36]
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [39:0]                      s_axis_tdata,
  // tuser: kind [1:0]
  input  wire logic [1:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: wipe_done [0], use_new_image [1], source_row [11:2], zero [15:12]
  output logic [15:0]                           m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [cmwe_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [cmwe_pkg::CfgW-1:0]        cfg_data_i
);

  logic [cmwe_pkg::CountW-1:0]  column_count_q;
  logic [cmwe_pkg::HeightW-1:0] screen_height_q;
  logic [cmwe_pkg::ScaleW-1:0]  scale_q;

  cmwe_pkg::cmd_t    cmd;
  cmwe_pkg::status_t status;
  cmwe_pkg::kind_e   kind;
  logic              acc;
  logic              wipe_done;
  logic              use_new_image;
  logic [cmwe_pkg::RowW-1:0] source_row;

  // Configuration: indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q  <= cmwe_pkg::ColumnCountRst;
      screen_height_q <= cmwe_pkg::ScreenHeightRst;
      scale_q         <= cmwe_pkg::ScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cmwe_pkg::CfgColumnCount:  column_count_q  <= cfg_data_i;
        cmwe_pkg::CfgScreenHeight: screen_height_q <= cfg_data_i;
        cmwe_pkg::CfgScale:        scale_q         <= cfg_data_i[cmwe_pkg::ScaleW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign kind = cmwe_pkg::kind_e'(s_axis_tuser);
  assign acc  = s_axis_tvalid && s_axis_tready;

  cmwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_acc_i (acc && (kind == cmwe_pkg::KIND_TICK)),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cmwe_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .acc_i           (acc),
    .kind_i          (kind),
    .column_i        (s_axis_tdata[9:0]),
    .row_i           (s_axis_tdata[19:10]),
    .offset_i        (s_axis_tdata[35:20]),
    .column_count_i  (column_count_q),
    .screen_height_i (screen_height_q),
    .scale_i         (scale_q),
    .s_ready_o       (s_axis_tready),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .wipe_done_o     (wipe_done),
    .use_new_image_o (use_new_image),
    .source_row_o    (source_row)
  );

  assign m_axis_tdata = {4'b0000, source_row, use_new_image, wipe_done};

endmodule

`default_nettype wire

### verif/tb_column_melt_wipe_engine_top.sv
// Testbench for the column melt wipe engine: directed and random beats checked by a melt predictor.

module tb_column_melt_wipe_engine_top;
  import cmwe_pkg::*;

  localparam int MaxCols   = 1024;
  localparam int IdleLimit = 10000;
  localparam int PressHold = 400;
  localparam int MaxReport = 10;

  typedef enum int {
    PACE_FULL,
    PACE_RANDOM,
    PACE_SPARSE
  } pace_e;

  typedef struct {
    kind_e            kind;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [OffsW-1:0] offs;
  } wipe_cmd_t;

  typedef struct {
    logic            done;
    logic            use_new;
    logic [RowW-1:0] src_row;
  } wipe_res_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata  = '0;
  logic [1:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [CfgW-1:0]    cfg_data_i    = '0;

  column_melt_wipe_engine_top #(
    .MAX_COLUMNS(MaxCols)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the offset store and the registers.
  logic signed [OffsW-1:0] melt_offs [MaxCols];
  logic [CountW-1:0]       melt_count  = ColumnCountRst;
  logic [HeightW-1:0]      melt_height = ScreenHeightRst;
  logic [ScaleW-1:0]       melt_scale  = ScaleRst;

  wipe_cmd_t pend_q [$];
  wipe_res_t melt_expq [$];
  wipe_cmd_t drv_cmd;
  wipe_res_t mon_got;
  wipe_res_t mon_want;

  pace_e tx_mode     = PACE_RANDOM;
  pace_e rx_mode     = PACE_RANDOM;
  bit    press_req   = 1'b0;
  bit    press_done  = 1'b0;
  int    tx_wait     = 0;
  int    rx_wait     = 0;
  int    press_left  = 0;
  int    idle_cycles = 0;
  int    err_cnt     = 0;
  int    items_made  = 0;
  int    loaded_hi   = 0;

  // Apply one beat to the predictor state and return the result it produces.
  function automatic wipe_res_t melt_step(wipe_cmd_t c);
    wipe_res_t res;
    int h16, half, thr, stp, n, d, r, row_i, x;
    res   = '{1'b0, 1'b0, '0};
    h16   = int'(melt_height) * 16;
    half  = int'(melt_scale) / 2;
    thr   = int'(melt_scale) * 16;
    stp   = int'(melt_scale) * 4;
    case (c.kind)
      KIND_LOAD: begin
        melt_offs[c.col] = c.offs;
      end
      KIND_TICK: begin
        n = (melt_count > MaxCols) ? MaxCols : int'(melt_count);
        res.done = 1'b1;
        for (x = 0; x < n; x++) begin
          d = melt_offs[x];
          if (d < h16) begin
            res.done = 1'b0;
            if (d < 0) d = d + half;
            else if (d < thr) d = 2 * d + half;
            else d = d + stp;
            if (d > h16) d = h16;
            melt_offs[x] = d[OffsW-1:0];
          end
        end
      end
      KIND_QUERY: begin
        d     = melt_offs[c.col];
        r     = (d > 0) ? (d >>> 4) : 0;
        row_i = c.row;
        if (r > int'(melt_height)) r = melt_height;
        if (row_i < r) begin
          res.use_new = 1'b1;
          res.src_row = c.row;
        end else begin
          res.src_row = RowW'(row_i - r);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pause_draw(pace_e mode);
    case (mode)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 19);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // Offsets of a well-formed wipe start mostly negative; some land inside the
  // screen and a few are arbitrary 16-bit noise.
  function automatic logic [OffsW-1:0] melt_offset(int h16);
    case ($urandom_range(0, 3))
      0, 1:    return OffsW'(0 - int'($urandom_range(0, 2048)));
      2:       return OffsW'($urandom_range(0, h16));
      default: return OffsW'($urandom);
    endcase
  endfunction

  function automatic int query_row(int height);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, (height > 1023) ? 1023 : height);
  endfunction

  function automatic void push_cmd(kind_e k, int col, int row, logic [OffsW-1:0] offs);
    wipe_cmd_t c;
    c.kind = k;
    c.col  = ColW'(col);
    c.row  = RowW'(row);
    c.offs = offs;
    pend_q.push_back(c);
    items_made++;
  endfunction

  function automatic void note_mismatch(string what, wipe_res_t want, wipe_res_t got);
    err_cnt++;
    if (err_cnt <= MaxReport)
      $display("%0t: %s: expected done=%0b new=%0b row=%0d, got done=%0b new=%0b row=%0d",
               $time, what, want.done, want.use_new, want.src_row,
               got.done, got.use_new, got.src_row);
  endfunction

  // Input driver: hold a beat until taken, predict it on acceptance, then
  // wait out the drawn gap before offering the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      tx_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        melt_expq.push_back(melt_step(drv_cmd));
        tx_wait = pause_draw(tx_mode);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          drv_cmd = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, drv_cmd.offs, drv_cmd.row, drv_cmd.col};
          s_axis_tuser  <= drv_cmd.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each result beat with the oldest expectation and
  // stall between beats; once on request, hold off for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait    = 0;
      press_left = 0;
      press_done = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        mon_got.done    = m_axis_tdata[0];
        mon_got.use_new = m_axis_tdata[1];
        mon_got.src_row = m_axis_tdata[11:2];
        if (melt_expq.size() == 0) begin
          note_mismatch("unexpected result", mon_got, mon_got);
        end else begin
          mon_want = melt_expq.pop_front();
          if (mon_got.done !== mon_want.done || mon_got.use_new !== mon_want.use_new ||
              mon_got.src_row !== mon_want.src_row)
            note_mismatch("result mismatch", mon_want, mon_got);
        end
        rx_wait = pause_draw(rx_mode);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (press_req && !press_done) begin
        press_left = PressHold;
        press_done = 1'b1;
      end
      if (press_left > 0) press_left--;
      m_axis_tready <= (rx_wait == 0) && (press_left == 0);
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgW'(val);
    case (idx)
      CfgColumnCount:  melt_count  = CountW'(val);
      CfgScreenHeight: melt_height = HeightW'(val);
      CfgScale:        melt_scale  = ScaleW'(val);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_wipe(int cnt, int height, int scale);
    cfg_write(CfgColumnCount, cnt);
    cfg_write(CfgScreenHeight, height);
    cfg_write(CfgScale, scale);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || s_axis_tvalid || melt_expq.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // One setting: start a fresh wipe on the walked columns (only the missing
  // ones when the count is large), then mostly queries with ticks, reloads
  // and a little noise mixed in.
  task automatic wipe_phase(int cnt, int height, int scale, int n_items,
                            pace_e txm, pace_e rxm, bit squeeze);
    int n, col, pick, h16, stop_at;
    set_wipe(cnt, height, scale);
    tx_mode = txm;
    rx_mode = rxm;
    n   = (cnt > MaxCols) ? MaxCols : cnt;
    h16 = height * 16;
    for (col = (n <= 64) ? 0 : loaded_hi; col < n; col++)
      push_cmd(KIND_LOAD, col, $urandom, melt_offset(h16));
    if (n > loaded_hi) loaded_hi = n;
    if (squeeze) press_req = 1'b1;
    stop_at = items_made + n_items;
    while (items_made < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < ((n > 64) ? 4 : 12))
        push_cmd(KIND_TICK, $urandom, $urandom, OffsW'($urandom));
      else if (pick < 75)
        push_cmd(KIND_QUERY, $urandom_range(0, loaded_hi - 1), query_row(height),
                 OffsW'($urandom));
      else if (pick < 90)
        push_cmd(KIND_LOAD, $urandom_range(0, loaded_hi - 1), $urandom, melt_offset(h16));
      else if (pick < 95)
        push_cmd(KIND_LOAD, $urandom_range(0, loaded_hi - 1), $urandom, OffsW'($urandom));
      else
        push_cmd(KIND_NOP, $urandom, $urandom, OffsW'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero count: a tick walks nothing and reports done. No-op with every
    // field bit set returns all zero. Loads hit the offset extremes, both
    // sides of the doubling threshold and the last column.
    set_wipe(0, 200, 16);
    push_cmd(KIND_TICK, 0, 0, '0);
    push_cmd(KIND_NOP, 1023, 1023, 16'hFFFF);
    push_cmd(KIND_LOAD, 0, 0, 16'h8000);
    push_cmd(KIND_LOAD, 1, 0, 16'h7FFF);
    push_cmd(KIND_LOAD, 2, 0, OffsW'(-2048));
    push_cmd(KIND_LOAD, 3, 0, OffsW'(16384));
    push_cmd(KIND_LOAD, 4, 0, OffsW'(255));
    push_cmd(KIND_LOAD, 5, 0, OffsW'(256));
    push_cmd(KIND_LOAD, 1023, 1023, '0);
    loaded_hi = 6;
    push_cmd(KIND_QUERY, 0, 0, '0);
    push_cmd(KIND_QUERY, 1, 1023, '0);
    push_cmd(KIND_QUERY, 3, 5, '0);
    push_cmd(KIND_QUERY, 4, 0, '0);
    push_cmd(KIND_QUERY, 4, 15, '0);
    push_cmd(KIND_QUERY, 5, 1023, '0);
    push_cmd(KIND_QUERY, 1023, 1023, '0);
    push_cmd(KIND_QUERY, 2, 512, '0);
    wait_drained();

    // One-row screen at a scale of 128: clamp to height, then finish.
    set_wipe(6, 1, 128);
    push_cmd(KIND_TICK, 0, 0, '0);
    push_cmd(KIND_QUERY, 1, 0, '0);
    push_cmd(KIND_QUERY, 0, 1023, '0);
    push_cmd(KIND_LOAD, 0, 0, '0);
    push_cmd(KIND_LOAD, 2, 0, OffsW'(15));
    push_cmd(KIND_TICK, 0, 0, '0);
    push_cmd(KIND_TICK, 0, 0, '0);
    wait_drained();

    wipe_phase(1, 1024, 16, 40, PACE_RANDOM, PACE_RANDOM, 1'b0);
    wipe_phase(16, 7, 33, 60, PACE_FULL, PACE_FULL, 1'b0);
    // Hold the output off while input beats keep coming, to fill the engine.
    wipe_phase(8, 50, 16, 80, PACE_FULL, PACE_FULL, 1'b1);
    wipe_phase(40, 100, 100, 50, PACE_SPARSE, PACE_RANDOM, 1'b0);
    wipe_phase(64, 1, 128, 40, PACE_RANDOM, PACE_SPARSE, 1'b0);
    wipe_phase(1024, 200, 16, 50, PACE_SPARSE, PACE_SPARSE, 1'b0);
    wipe_phase(2047, 1024, 128, 30, PACE_RANDOM, PACE_FULL, 1'b0);
    wipe_phase(0, 30, 64, 20, PACE_FULL, PACE_RANDOM, 1'b0);
    wipe_phase(320, 200, 16, 20, PACE_SPARSE, PACE_RANDOM, 1'b0);
    wipe_phase($urandom_range(1, 48), $urandom_range(1, 64), $urandom_range(16, 128), 50,
               PACE_RANDOM, PACE_RANDOM, 1'b0);

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && melt_expq.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
